[hw/rtl/lphi_pkg.sv]
// shared constants and types for the linear probing hash insert block
// no dependencies; the other files, except lphi_ram, refer to this package by scoped names
package lphi_pkg;

  // table geometry; table size follows from the slot width (power of two)
  localparam int SLOT_W     = 7;
  localparam int TABLE_SIZE = 1 << SLOT_W;
  localparam int COUNT_W    = SLOT_W + 1;
  localparam int VALUE_W    = 14;
  localparam int STATUS_W   = 2;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_HOME   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PROBED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_READ   = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic capture;  // take the request payload, start the slot read
    logic finish;   // carry out the request and load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rsp_free;  // result register empty or being taken this cycle
  } sts_t;

endpackage

[hw/rtl/lphi_req_if.sv]
// request channel: valid/ready handshake with the request payload
// depends on lphi_pkg
interface lphi_req_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [lphi_pkg::VALUE_W-1:0]  value;
  logic [lphi_pkg::SLOT_W-1:0]   slot_index;

  modport source (output valid, output operation, output value, output slot_index,
                  input ready);
  modport sink   (input valid, input operation, input value, input slot_index,
                  output ready);
endinterface

[hw/rtl/lphi_rsp_if.sv]
// result channel: valid/ready handshake with the result payload
// depends on lphi_pkg
interface lphi_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lphi_pkg::STATUS_W-1:0] status;
  logic [lphi_pkg::SLOT_W-1:0]   slot;
  logic [lphi_pkg::VALUE_W-1:0]  read_value;
  logic                          read_occupied;

  modport source (output valid, output status, output slot, output read_value,
                  output read_occupied, input ready);
  modport sink   (input valid, input status, input slot, input read_value,
                  input read_occupied, output ready);
endinterface

[hw/rtl/lphi_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
module lphi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/lphi_ctrl.sv]
// controller: two-state sequencer for capture and execute of one request
// depends on lphi_pkg
module lphi_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  lphi_pkg::sts_t   sts,
  output lphi_pkg::cmd_t   cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  assign req_ready   = (state == S_IDLE);
  assign cmd.capture = (state == S_IDLE) && req_valid;
  assign cmd.finish  = (state == S_EXEC) && sts.rsp_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hw/rtl/lphi_datapath.sv]
// datapath: request registers, occupancy flops, free slot search, value ram
// and result register; depends on lphi_pkg and lphi_ram
module lphi_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  lphi_pkg::cmd_t                 cmd,
  output lphi_pkg::sts_t                 sts,
  input  logic                           req_operation,
  input  logic [lphi_pkg::VALUE_W-1:0]   req_value,
  input  logic [lphi_pkg::SLOT_W-1:0]    req_slot_index,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [lphi_pkg::STATUS_W-1:0]  rsp_status,
  output logic [lphi_pkg::SLOT_W-1:0]    rsp_slot,
  output logic [lphi_pkg::VALUE_W-1:0]   rsp_read_value,
  output logic                           rsp_read_occupied
);

  logic                            op;
  logic [lphi_pkg::VALUE_W-1:0]    value;
  logic [lphi_pkg::SLOT_W-1:0]     idx;
  logic [lphi_pkg::TABLE_SIZE-1:0] occ;
  logic [lphi_pkg::COUNT_W-1:0]    occupied_count;

  logic [lphi_pkg::SLOT_W-1:0]       home;
  logic [2*lphi_pkg::TABLE_SIZE-1:0] occ_twice;
  logic [lphi_pkg::TABLE_SIZE-1:0]   rot_free;
  logic [lphi_pkg::TABLE_SIZE-1:0]   first_free;
  logic [lphi_pkg::SLOT_W-1:0]       offset;
  logic [lphi_pkg::SLOT_W-1:0]       found;
  logic                              full;
  logic                              do_write;
  logic [lphi_pkg::VALUE_W-1:0]      ram_rdata;
  logic                              idx_occ;

  // home slot is the value modulo the table size
  assign home = value[lphi_pkg::SLOT_W-1:0];

  // rotate occupancy so that home sits at bit 0, then pick the lowest free bit
  assign occ_twice  = {occ, occ} >> home;
  assign rot_free   = ~occ_twice[lphi_pkg::TABLE_SIZE-1:0];
  assign first_free = rot_free & (-rot_free);

  always_comb begin
    offset = '0;
    for (int b = 0; b < lphi_pkg::SLOT_W; b++) begin
      for (int i = 0; i < lphi_pkg::TABLE_SIZE; i++) begin
        if (((i >> b) & 1) == 1) begin
          offset[b] = offset[b] | first_free[i];
        end
      end
    end
  end

  assign found    = home + offset;
  assign full     = (occupied_count == lphi_pkg::COUNT_W'(lphi_pkg::TABLE_SIZE));
  assign do_write = cmd.finish && (op == lphi_pkg::OP_INSERT) && !full;
  assign idx_occ  = occ[idx];

  assign sts.rsp_free = !rsp_valid || rsp_ready;

  lphi_ram #(
    .WIDTH (lphi_pkg::VALUE_W),
    .DEPTH (lphi_pkg::TABLE_SIZE)
  ) u_values (
    .clk   (clk),
    .we    (do_write),
    .waddr (found),
    .wdata (value),
    .re    (cmd.capture),
    .raddr (req_slot_index),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= req_operation;
      value <= req_value;
      idx   <= req_slot_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ            <= '0;
      occupied_count <= '0;
    end else if (do_write) begin
      occ[found]     <= 1'b1;
      occupied_count <= occupied_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= cmd.finish || (rsp_valid && !rsp_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (op == lphi_pkg::OP_READ) begin
        rsp_status        <= lphi_pkg::ST_READ;
        rsp_slot          <= idx;
        rsp_read_value    <= idx_occ ? ram_rdata : '0;
        rsp_read_occupied <= idx_occ;
      end else if (full) begin
        rsp_status        <= lphi_pkg::ST_FULL;
        rsp_slot          <= '0;
        rsp_read_value    <= '0;
        rsp_read_occupied <= 1'b0;
      end else begin
        rsp_status        <= (offset == '0) ? lphi_pkg::ST_HOME : lphi_pkg::ST_PROBED;
        rsp_slot          <= found;
        rsp_read_value    <= '0;
        rsp_read_occupied <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/linear_probe_hash_insert.sv]
// linear probing hash table: insert a value or read back one slot
// channels: request on req (sink), result on rsp (source)
// uses lphi_pkg, lphi_req_if, lphi_rsp_if, lphi_ctrl and lphi_datapath
//
// req carries operation, value and slot_index; every accepted request gives
// exactly one result on rsp with status, slot, read_value and read_occupied
// an insert stores the value at its home slot (value modulo table size) or,
// if that is taken, at the first free slot found going upward and wrapping
// round to slot 0; with all slots taken it reports full and writes nothing
// a read returns the slot's value and occupancy, value shown as 0 when free
//
// the request registers load when a request is accepted and the result
// register when execute finishes; a new request is taken only once the
// controller is back in capture; the free slot search over the occupancy
// flops and the value ram write both happen in the execute state
//
// reset clears the occupancy flops, the count of stored values, the
// controller state and the result valid; the value ram is not cleared
// if the receiver stalls, the finished result waits in the result register
// while the next request is still taken; that request then holds in execute
// until the register frees up, and req.ready stays low meanwhile
module linear_probe_hash_insert (
  input logic         clk,
  input logic         rst,
  lphi_req_if.sink    req,
  lphi_rsp_if.source  rsp
);

  // command and status between controller and datapath
  lphi_pkg::cmd_t cmd;
  lphi_pkg::sts_t sts;

  lphi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lphi_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .req_operation     (req.operation),
    .req_value         (req.value),
    .req_slot_index    (req.slot_index),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_slot          (rsp.slot),
    .rsp_read_value    (rsp.read_value),
    .rsp_read_occupied (rsp.read_occupied)
  );

endmodule
